@@ design/qph_pkg.sv @@
// ----------------------------------------------------------------------------
// qph_pkg: shared types and constants of the quadratic probe hash table
// Field widths, action and status codes, slot tags and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package qph_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int KEY_WIDTH_DEF   = 31;

    localparam int BUCKET_W  = 7;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 6;
    localparam int PROBE_W   = 7;
    localparam int TAG_W     = 2;

    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 7'd7;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [TAG_W-1:0]    tag_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_DELETE = 2'd1;
    localparam action_t ACT_SEARCH = 2'd2;

    localparam status_t ST_INSERTED = 3'd0;
    localparam status_t ST_DELETED  = 3'd1;
    localparam status_t ST_FOUND    = 3'd2;
    localparam status_t ST_MISSING  = 3'd3;
    localparam status_t ST_FULL     = 3'd4;

    localparam tag_t TAG_EMPTY = 2'd0;
    localparam tag_t TAG_USED  = 2'd1;
    localparam tag_t TAG_GONE  = 2'd2;

endpackage

`default_nettype wire

@@ design/qph_req_if.sv @@
// ----------------------------------------------------------------------------
// qph_req_if: request channel of the hash table
// Carries one table operation (action and key) with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qph_req_if #(
    parameter int KEY_WIDTH = qph_pkg::KEY_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [qph_pkg::ACTION_W-1:0]  action;
    logic [KEY_WIDTH-1:0]          key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

`default_nettype wire

@@ design/qph_rsp_if.sv @@
// ----------------------------------------------------------------------------
// qph_rsp_if: response channel of the hash table
// Carries the status, slot and probe count of one finished request.
// ----------------------------------------------------------------------------
`default_nettype none

interface qph_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [qph_pkg::STATUS_W-1:0]  status;
    logic [qph_pkg::SLOT_W-1:0]    slot;
    logic [qph_pkg::PROBE_W-1:0]   probe_count;

    modport source (output valid, output status, output slot, output probe_count,
                    input ready);
    modport sink   (input valid, input status, input slot, input probe_count,
                    output ready);
endinterface

`default_nettype wire

@@ design/qph_cfg_if.sv @@
// ----------------------------------------------------------------------------
// qph_cfg_if: configuration write channel of the hash table
// Carries the bucket count register write with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qph_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [qph_pkg::BUCKET_W-1:0]  bucket_count;

    modport source (output valid, output bucket_count, input ready);
    modport sink   (input valid, input bucket_count, output ready);
endinterface

`default_nettype wire

@@ design/quadratic_probe_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top: open-addressed key table, quadratic probing
//
// Requests arrive on req (insert, delete or search of a key) and each one
// gives exactly one response on rsp: status, slot and probe count. The cfg
// channel writes bucket_count, the table size used as probing modulus; it is
// always ready. The user must write it only while no request is in flight;
// the block does not enforce this. After reset the slot memory is swept to
// empty, one slot per cycle; req is not ready during that sweep.
// A request is accepted, then its home slot is found (key mod size, one key
// bit per cycle through the shared reduce unit), then each probe is a
// registered memory read followed by a decision, and last the result is
// handed to the output register. An unknown action skips the home slot and
// the probes and goes straight to the output register with no probes.
// One request is worked on at a time. The response sits in an output
// register, so a stalled receiver does not stop the next request from being
// accepted; it only holds the finished one until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_table_top #(
    parameter int TABLE_SLOTS = qph_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_WIDTH   = qph_pkg::KEY_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qph_req_if.sink   req,
    qph_rsp_if.source rsp,
    qph_cfg_if.sink   cfg
);
    import qph_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_SLOTS);
    localparam int BIT_W    = $clog2(KEY_WIDTH);
    localparam int ROW_W    = TAG_W + KEY_WIDTH;
    localparam int SIZE_CAP = (TABLE_SLOTS < 127) ? TABLE_SLOTS : 127;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [BUCKET_W-1:0]    bucket_reg;
    action_t                action_reg, action_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [BUCKET_W-1:0]    idx_reg, idx_next;
    logic [BUCKET_W-1:0]    delta_reg, delta_next;
    logic [PROBE_W-1:0]     probe_reg, probe_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    status_t                res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [PROBE_W-1:0]     res_probes_reg, res_probes_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [PROBE_W-1:0]     out_probes_reg, out_probes_next;

    logic [BUCKET_W-1:0]    size;
    logic [BUCKET_W:0]      unit_in;
    logic [BUCKET_W-1:0]    unit_out;

    logic [ROW_W-1:0]       mem [TABLE_SLOTS];
    logic [ROW_W-1:0]       rd_row_reg;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ROW_W-1:0]       wr_row;
    tag_t                   rd_tag;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [PROBE_W-1:0]     probe_inc;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.probe_count = out_probes_reg;

    // Active size: zero acts as one, anything above the table acts as the table.
    always_comb
    begin
        if (bucket_reg == '0)
        begin
            size = BUCKET_W'(1);
        end
        else if (32'(bucket_reg) > SIZE_CAP)
        begin
            size = BUCKET_W'(SIZE_CAP);
        end
        else
        begin
            size = bucket_reg;
        end
    end

    // Shared reduce unit: the operand is below twice the size whenever the size is above one.
    always_comb
    begin
        case (state_reg)
            S_MOD:   unit_in = {idx_reg, key_reg[bit_cnt_reg]};
            S_READ:  unit_in = {1'b0, delta_reg} + (BUCKET_W + 1)'(2);
            S_CHECK: unit_in = {1'b0, idx_reg} + {1'b0, delta_reg};
            default: unit_in = '0;
        endcase
        if (unit_in >= {1'b0, size})
        begin
            unit_out = BUCKET_W'(unit_in - {1'b0, size});
        end
        else
        begin
            unit_out = BUCKET_W'(unit_in);
        end
    end

    assign rd_tag    = rd_row_reg[ROW_W-1 -: TAG_W];
    assign rd_key    = rd_row_reg[KEY_WIDTH-1:0];
    assign probe_inc = probe_reg + PROBE_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        delta_next      = delta_reg;
        probe_next      = probe_reg;
        bit_cnt_next    = bit_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_probes_next = res_probes_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_probes_next = out_probes_reg;
        wr_en           = 1'b0;
        wr_addr         = IDX_W'(idx_reg);
        wr_row          = {TAG_USED, key_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_row  = {TAG_EMPTY, {KEY_WIDTH{1'b0}}};
                if (clr_cnt_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    action_next  = req.action;
                    key_next     = req.key;
                    idx_next     = '0;
                    probe_next   = '0;
                    bit_cnt_next = BIT_W'(KEY_WIDTH - 1);
                    if (req.action == ACT_INSERT || req.action == ACT_DELETE ||
                        req.action == ACT_SEARCH)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        res_status_next = ST_MISSING;
                        res_slot_next   = '0;
                        res_probes_next = '0;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_MOD:
            begin
                // Remainder accumulates MSB first; it ends as the home slot.
                idx_next = unit_out;
                if (bit_cnt_reg == '0)
                begin
                    // Offset step starts at -1 so the read cycle brings it to 2b+1.
                    delta_next = size - BUCKET_W'(1);
                    state_next = S_READ;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                end
            end
            S_READ:
            begin
                delta_next = unit_out;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                probe_next = probe_inc;
                if (action_reg == ACT_INSERT && rd_tag != TAG_USED)
                begin
                    wr_en           = 1'b1;
                    wr_row          = {TAG_USED, key_reg};
                    res_status_next = ST_INSERTED;
                    res_slot_next   = SLOT_W'(idx_reg);
                    res_probes_next = probe_inc;
                    state_next      = S_FINISH;
                end
                else if (action_reg != ACT_INSERT && rd_tag == TAG_EMPTY)
                begin
                    res_status_next = ST_MISSING;
                    res_slot_next   = '0;
                    res_probes_next = probe_inc;
                    state_next      = S_FINISH;
                end
                else if (action_reg != ACT_INSERT && rd_tag == TAG_USED &&
                         rd_key == key_reg)
                begin
                    if (action_reg == ACT_DELETE)
                    begin
                        wr_en           = 1'b1;
                        wr_row          = {TAG_GONE, rd_key};
                        res_status_next = ST_DELETED;
                    end
                    else
                    begin
                        res_status_next = ST_FOUND;
                    end
                    res_slot_next   = SLOT_W'(idx_reg);
                    res_probes_next = probe_inc;
                    state_next      = S_FINISH;
                end
                else if (probe_inc == PROBE_W'(size))
                begin
                    res_status_next = (action_reg == ACT_INSERT) ? ST_FULL : ST_MISSING;
                    res_slot_next   = '0;
                    res_probes_next = PROBE_W'(size);
                    state_next      = S_FINISH;
                end
                else
                begin
                    idx_next   = unit_out;
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_probes_next = res_probes_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            bucket_reg     <= BUCKET_RESET;
            action_reg     <= ACT_INSERT;
            key_reg        <= '0;
            idx_reg        <= '0;
            delta_reg      <= '0;
            probe_reg      <= '0;
            bit_cnt_reg    <= '0;
            clr_cnt_reg    <= '0;
            res_status_reg <= ST_INSERTED;
            res_slot_reg   <= '0;
            res_probes_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_INSERTED;
            out_slot_reg   <= '0;
            out_probes_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            action_reg     <= action_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            delta_reg      <= delta_next;
            probe_reg      <= probe_next;
            bit_cnt_reg    <= bit_cnt_next;
            clr_cnt_reg    <= clr_cnt_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_probes_reg <= res_probes_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_probes_reg <= out_probes_next;
            if (cfg.valid)
            begin
                bucket_reg <= cfg.bucket_count;
            end
        end
    end

    // Slot memory: tag and key per row, one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= mem[IDX_W'(idx_reg)];
    end

endmodule

`default_nettype wire

@@ verif/quadratic_probe_hash_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top_tb: self-checking bench of the hash table
// Sends insert, delete, search and unknown requests, first directed and then
// random over many table sizes. A built-in model of the slot memory predicts
// every response, and a checker compares each one field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_table_top_tb;

    import qph_pkg::*;

    localparam int      KW          = KEY_WIDTH_DEF;
    localparam action_t ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [PROBE_W-1:0]  probes;
    } table_answer_t;

    logic clk;
    logic rst_n;

    qph_req_if #(.KEY_WIDTH(KW)) req_if();
    qph_rsp_if                   rsp_if();
    qph_cfg_if                   cfg_if();

    quadratic_probe_hash_table_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Shadow copy of the slot memory and of the size register.
    logic [KW-1:0]       shadow_key [TABLE_SLOTS_DEF];
    tag_t                shadow_tag [TABLE_SLOTS_DEF];
    logic [BUCKET_W-1:0] shadow_size;

    table_answer_t answers_due[$];
    logic [KW-1:0] live_keys[$];
    int            mismatches;
    bit            steady;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("[quadratic_probe_hash_table_top] ERROR");
        $finish;
    end

    function automatic table_answer_t probe_table(input action_t act, input logic [KW-1:0] k);
        table_answer_t a;
        int unsigned   n;
        int unsigned   home;
        int unsigned   idx;
        bit            done;
        a.status = ST_MISSING;
        a.slot   = '0;
        a.probes = '0;
        if (act == ACT_UNKNOWN)
            return a;
        if (shadow_size == 0)
            n = 1;
        else if (shadow_size > TABLE_SLOTS_DEF)
            n = TABLE_SLOTS_DEF;
        else
            n = shadow_size;
        home     = k % n;
        a.status = (act == ACT_INSERT) ? ST_FULL : ST_MISSING;
        a.probes = n[PROBE_W-1:0];
        done     = 1'b0;
        for (int unsigned b = 0; b < n && !done; b++)
        begin
            idx = (home + b * b) % n;
            if (act == ACT_INSERT)
            begin
                // Insert reuses tombstones and never looks for a duplicate.
                if (shadow_tag[idx] != TAG_USED)
                begin
                    shadow_key[idx] = k;
                    shadow_tag[idx] = TAG_USED;
                    a.status = ST_INSERTED;
                    a.slot   = idx[SLOT_W-1:0];
                    a.probes = PROBE_W'(b + 1);
                    done     = 1'b1;
                end
            end
            else if (shadow_tag[idx] == TAG_EMPTY)
            begin
                a.probes = PROBE_W'(b + 1);
                done     = 1'b1;
            end
            else if (shadow_tag[idx] == TAG_USED && shadow_key[idx] == k)
            begin
                if (act == ACT_DELETE)
                begin
                    shadow_tag[idx] = TAG_GONE;
                    a.status = ST_DELETED;
                end
                else
                begin
                    a.status = ST_FOUND;
                end
                a.slot   = idx[SLOT_W-1:0];
                a.probes = PROBE_W'(b + 1);
                done     = 1'b1;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic check_answer();
        table_answer_t want;
        if (answers_due.size() == 0)
        begin
            report_mismatch("response with no request outstanding, status",
                            rsp_if.status, 0);
        end
        else
        begin
            want = answers_due.pop_front();
            if (rsp_if.status !== want.status)
                report_mismatch("status", rsp_if.status, want.status);
            if (rsp_if.slot !== want.slot)
                report_mismatch("slot", rsp_if.slot, want.slot);
            if (rsp_if.probe_count !== want.probes)
                report_mismatch("probe_count", rsp_if.probe_count, want.probes);
        end
    endtask

    // Response side: check each accepted response, stall at random.
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                check_answer();
            rsp_if.ready <= steady || ($urandom_range(99) >= 21);
        end
    end

    // Called at a rising edge. Valid stays high after acceptance so that the
    // next request can follow back to back; callers lower it at phase ends.
    task automatic send_op(input action_t act, input logic [KW-1:0] k);
        int gap;
        gap = (!steady && $urandom_range(99) < 21) ? $urandom_range(1, 40) : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.key    <= k;
        do @(posedge clk); while (!req_if.ready);
        answers_due.push_back(probe_table(act, k));
    endtask

    task automatic write_bucket_count(input logic [BUCKET_W-1:0] v);
        req_if.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.bucket_count <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        shadow_size = v;
    endtask

    task automatic run_random_ops(input int count, input int insert_pct);
        action_t       act;
        logic [KW-1:0] k;
        int            r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (live_keys.size() != 0 && r < 50)
                k = live_keys[$urandom_range(live_keys.size() - 1)];
            else if (r < 75)
                k = KW'($urandom());
            else
                k = KW'($urandom_range(300));
            r = $urandom_range(99);
            if (r < 3)
                act = ACT_UNKNOWN;
            else if (r < 3 + insert_pct)
                act = ACT_INSERT;
            else if (r < 3 + insert_pct + (97 - insert_pct) / 2)
                act = ACT_DELETE;
            else
                act = ACT_SEARCH;
            if (act == ACT_INSERT)
            begin
                live_keys.push_back(k);
                if (live_keys.size() > 96)
                    void'(live_keys.pop_front());
            end
            send_op(act, k);
        end
    endtask

    // Reset size of 7: chains, tombstones, duplicates, a full probe path and
    // the unknown action.
    task automatic test_default_size();
        send_op(ACT_SEARCH, 31'd5);
        send_op(ACT_DELETE, 31'd5);
        send_op(ACT_INSERT, 31'd0);
        send_op(ACT_INSERT, 31'd7);
        send_op(ACT_INSERT, 31'd14);
        send_op(ACT_INSERT, 31'd21);
        send_op(ACT_INSERT, 31'd28);
        send_op(ACT_SEARCH, 31'd21);
        send_op(ACT_DELETE, 31'd7);
        send_op(ACT_SEARCH, 31'd14);
        send_op(ACT_SEARCH, 31'd7);
        send_op(ACT_INSERT, 31'd0);
        send_op(ACT_DELETE, 31'd0);
        send_op(ACT_SEARCH, 31'd0);
        send_op(ACT_INSERT, 31'h7FFF_FFFF);
        send_op(ACT_SEARCH, 31'h7FFF_FFFF);
        send_op(ACT_UNKNOWN, 31'h7FFF_FFFF);
        send_op(ACT_UNKNOWN, 31'd0);
    endtask

    // One slot, a size of zero that acts as one, and sizes at and above the
    // memory depth.
    task automatic test_size_limits();
        write_bucket_count(7'd1);
        send_op(ACT_INSERT, 31'd9);
        send_op(ACT_INSERT, 31'd3);
        send_op(ACT_SEARCH, 31'd3);
        send_op(ACT_DELETE, 31'd9);
        send_op(ACT_INSERT, 31'd3);
        write_bucket_count(7'd0);
        send_op(ACT_SEARCH, 31'd3);
        write_bucket_count(7'd127);
        send_op(ACT_INSERT, 31'd63);
        send_op(ACT_INSERT, 31'd127);
        send_op(ACT_SEARCH, 31'd127);
        write_bucket_count(7'd64);
        send_op(ACT_SEARCH, 31'h7FFF_FFFF);
    endtask

    task automatic test_random_sizes();
        write_bucket_count(7'd64);
        run_random_ops(250, 50);
        write_bucket_count(7'd13);
        run_random_ops(150, 45);
        write_bucket_count(7'd0);
        run_random_ops(60, 40);
        write_bucket_count(7'd127);
        run_random_ops(150, 55);
        write_bucket_count(7'd2);
        run_random_ops(80, 40);
        write_bucket_count(7'd5);
        run_random_ops(150, 35);
        write_bucket_count(7'd32);
        run_random_ops(200, 45);
        write_bucket_count(7'd100);
        run_random_ops(120, 30);
        write_bucket_count(7'd1);
        run_random_ops(100, 40);
        write_bucket_count(7'd7);
        run_random_ops(150, 45);
    endtask

    // Back-to-back requests with the receiver always ready.
    task automatic test_steady_stream();
        write_bucket_count(7'd20);
        steady = 1'b1;
        run_random_ops(240, 45);
        steady = 1'b0;
    endtask

    initial
    begin
        mismatches  = 0;
        steady      = 1'b0;
        shadow_size = BUCKET_RESET;
        for (int i = 0; i < TABLE_SLOTS_DEF; i++)
        begin
            shadow_tag[i] = TAG_EMPTY;
            shadow_key[i] = '0;
        end
        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.action       <= ACT_INSERT;
        req_if.key          <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.bucket_count <= BUCKET_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_size_limits();
        test_random_sizes();
        test_steady_stream();

        req_if.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("[quadratic_probe_hash_table_top] OK");
        else
            $display("[quadratic_probe_hash_table_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
